/* hdl/cvd_pkg.sv */
package cvd_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_ZERO  = 2'd2,
    ST_BIG   = 2'd3
  } status_t;

  // Value width, sampled from the action field on a value's first byte.
  typedef enum logic [1:0] {
    WM_U64 = 2'd0,
    WM_U32 = 2'd1,
    WM_I32 = 2'd2
  } width_t;

  localparam logic [1:0] ACT_U64 = 2'd0;
  localparam logic [1:0] ACT_U32 = 2'd1;
  localparam logic [1:0] ACT_I32 = 2'd2;

  localparam logic [3:0] FINAL_IDX_U64 = 4'd9;
  localparam logic [3:0] FINAL_IDX_32  = 4'd4;
  localparam logic [7:0] LIMIT_U64     = 8'd1;
  localparam logic [7:0] LIMIT_U32     = 8'd15;
  localparam logic [7:0] LIMIT_I32     = 8'd7;

  localparam int QUEUE_DEPTH = 2;

  // One classified byte, passed from the front to the back.
  typedef struct packed {
    logic [6:0] payload;  // value bits of this byte
    logic [5:0] shamt;    // bit position of those bits in the value
    logic       emit;     // this byte closes the value
    status_t    status;
    logic [3:0] length;
  } entry_t;

  // Bit position of the seven value bits of byte number idx.
  function automatic logic [5:0] shift_for(input logic [3:0] idx);
    logic [6:0] s;
    s = {idx, 3'b000} - {3'b000, idx};
    return s[5:0];
  endfunction

endpackage

/* hdl/cvd_front.sv */
module cvd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           buffer_end,
  input  logic [1:0]     action,
  output cvd_pkg::entry_t entry
);
  import cvd_pkg::*;

  logic [3:0] idx;
  logic [3:0] idx_next;
  width_t     wm;
  width_t     wm_next;

  logic [3:0] final_idx;
  logic [7:0] limit;
  logic [3:0] len_here;

  // Classify the byte against the index and width of the value in progress.
  always_comb begin
    if (idx == 4'd0) begin
      unique case (action)
        ACT_U32: wm_next = WM_U32;
        ACT_I32: wm_next = WM_I32;
        default: wm_next = WM_U64;
      endcase
    end else begin
      wm_next = wm;
    end

    unique case (wm_next)
      WM_U32:  begin final_idx = FINAL_IDX_32;  limit = LIMIT_U32; end
      WM_I32:  begin final_idx = FINAL_IDX_32;  limit = LIMIT_I32; end
      default: begin final_idx = FINAL_IDX_U64; limit = LIMIT_U64; end
    endcase

    len_here      = idx + 4'd1;
    entry.payload = data_byte[6:0];
    entry.shamt   = shift_for(idx);
    entry.length  = len_here;
    entry.emit    = 1'b1;
    entry.status  = ST_OK;

    priority if (idx == 4'd0) begin
      if (data_byte[7] && buffer_end) begin
        entry.status = ST_TRUNC;
      end else if (data_byte[7]) begin
        entry.emit = 1'b0;
      end
    end else if (data_byte == 8'd0) begin
      entry.status = ST_ZERO;
    end else if (idx == final_idx) begin
      if (data_byte > limit) begin
        entry.status = ST_BIG;
      end
    end else if (data_byte[7] && buffer_end) begin
      entry.status = ST_TRUNC;
    end else if (data_byte[7]) begin
      entry.emit = 1'b0;
    end else begin
      // A byte without the continuation bit completes the value.
      entry.emit = 1'b1;
    end

    idx_next = entry.emit ? 4'd0 : len_here;
  end

  // Index and width of the value in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
      wm  <= WM_U64;
    end else if (accept) begin
      idx <= idx_next;
      wm  <= wm_next;
    end
  end

endmodule

/* hdl/cvd_queue.sv */
module cvd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cvd_pkg::entry_t push_data,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output cvd_pkg::entry_t pop_data
);
  import cvd_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  entry_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  assign not_full  = (count != PtrW'(0) + (PtrW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Pointer and fill-count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/cvd_back.sv */
module cvd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            entry_valid,
  input  cvd_pkg::entry_t entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     value,
  output logic [3:0]      length,
  output logic [1:0]      status
);
  import cvd_pkg::*;

  logic [63:0] acc;
  logic [63:0] contrib;
  logic [63:0] merged;
  logic        out_free;

  // Place the byte's value bits; they never overlap bits already gathered.
  assign contrib  = {57'd0, entry.payload} << entry.shamt;
  assign merged   = acc | contrib;
  assign out_free = !out_valid || out_ready;
  assign pop      = entry_valid && (!entry.emit || out_free);

  // Accumulator and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        acc <= entry.emit ? '0 : merged;
      end
      if (pop && entry.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop && entry.emit) begin
      value  <= (entry.status == ST_OK) ? merged : '0;
      length <= entry.length;
      status <= entry.status;
    end
  end

endmodule

/* hdl/checked_varint_decoder.sv */
// A byte that closes a value passes through the queue and the output register before
// its result shows on out_valid. Throughput: one byte per cycle while the queue
// has room; a two-entry queue lets front and back stall apart.
// The output register lets the next byte in while a finished result waits for out_ready.
// Reset (rst, synchronous, active high) clears the value in progress, the queue and
// out_valid; the width returns to 64-bit unsigned.
module checked_varint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  logic [1:0]  action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [3:0]  length,
  output logic [1:0]  status
);
  import cvd_pkg::*;

  entry_t in_entry;
  entry_t q_entry;
  logic   accept;
  logic   q_valid;
  logic   q_pop;

  assign accept = in_valid && in_ready;

  // Front: tracks position and width, classifies each byte.
  cvd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .action     (action),
    .entry      (in_entry)
  );

  // Queue between classification and assembly.
  cvd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (in_entry),
    .not_full  (in_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_entry)
  );

  // Back: assembles the value and holds the result.
  cvd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (q_valid),
    .entry       (q_entry),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .length      (length),
    .status      (status)
  );

endmodule

/* hdl/cvd_checker.sv */
module cvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic [3:0]  length,
  input logic [1:0]  status
);
  import cvd_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(length)
      && $stable(status))
    else $error("result changed while stalled");

  // A failed value reports zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> value == 64'd0)
    else $error("failed value is not zero");

  // Length is one to ten bytes.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length != 4'd0) && (length <= 4'd10))
    else $error("length out of range");

  // A one-byte value is below 128.
  a_one_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) && (length == 4'd1) |-> value < 64'd128)
    else $error("one-byte value too large");

  // No result right after reset.
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind checked_varint_decoder cvd_checker u_cvd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .length    (length),
  .status    (status)
);

/* test/tb_checked_varint_decoder.sv */
`timescale 1ns / 1ps

module tb_checked_varint_decoder;
  import cvd_pkg::*;

  // The unused action code decodes as 64-bit unsigned.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_BYTES = 230;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  length;
    status_t     status;
  } varint_result_t;

  typedef struct packed {
    logic [7:0]     data;
    logic           last;
    logic [1:0]     act;
    logic           typed;
    varint_result_t exp;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        buffer_end = 1'b0;
  logic [1:0]  action = ACT_U64;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] value;
  logic [3:0]  length;
  logic [1:0]  status;

  // Expectation typed into the directed table for the byte now on the bus.
  logic           row_typed = 1'b0;
  varint_result_t row_exp = '0;

  // Decoder state as predicted.
  logic [63:0] acc_q = 64'd0;
  logic [3:0]  digit_idx = 4'd0;
  width_t      mode_q = WM_U64;

  byte_item_t     stim_q[$];
  varint_result_t pending_results[$];
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  checked_varint_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .action     (action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .length     (length),
    .status     (status)
  );

  always #2 clk = ~clk;

  // Advances the predicted decoder by one byte; returns 1 when the byte closes a value.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     input logic [1:0] act, output varint_result_t r);
    logic [3:0] fin;
    logic [3:0] pos;
    logic [7:0] lim;
    bit         done;
    r = '{value: 64'd0, length: 4'd1, status: ST_OK};
    done = 1'b0;
    if (digit_idx == 4'd0) begin
      mode_q = (act == ACT_SPARE) ? WM_U64 : width_t'(act);
      done = 1'b1;
      if (!b[7]) begin
        r.value = {56'd0, b};
      end else if (last) begin
        r.status = ST_TRUNC;
      end else begin
        acc_q = {57'd0, b[6:0]};
        digit_idx = 4'd1;
        done = 1'b0;
      end
    end else begin
      fin = (mode_q == WM_U64) ? FINAL_IDX_U64 : FINAL_IDX_32;
      pos = (digit_idx > fin) ? fin : digit_idx;
      r.length = pos + 4'd1;
      done = 1'b1;
      if (b == 8'd0) begin
        r.status = ST_ZERO;
      end else if (pos == fin) begin
        // The final byte carries only the top bits of the width.
        lim = (mode_q == WM_U64) ? LIMIT_U64 : (mode_q == WM_U32) ? LIMIT_U32 : LIMIT_I32;
        if (b > lim) begin
          r.status = ST_BIG;
        end else if (mode_q == WM_U64) begin
          r.value = acc_q | 64'h8000_0000_0000_0000;
        end else begin
          r.value = acc_q + ({56'd0, b} << 28);
        end
      end else if (!b[7]) begin
        r.value = acc_q + ({56'd0, b} << (7 * pos));
      end else begin
        acc_q = acc_q + ({57'd0, b[6:0]} << (7 * pos));
        if (last) begin
          r.status = ST_TRUNC;
        end else begin
          digit_idx = pos + 4'd1;
          done = 1'b0;
        end
      end
    end
    if (done) begin
      acc_q = 64'd0;
      digit_idx = 4'd0;
    end
    return done;
  endfunction

  function automatic void push_byte(input logic [7:0] d, input logic e, input logic [1:0] a,
                                    input logic typed = 1'b0,
                                    input varint_result_t r = '0);
    stim_q.push_back('{data: d, last: e, act: a, typed: typed, exp: r});
  endfunction

  // Queues one value: mostly well-formed encodings with random content, some broken
  // ones, and some plain noise.
  task automatic plan_value();
    logic [1:0] act;
    logic [7:0] tail;
    logic       tail_end;
    width_t     m;
    int         fin;
    int         lim;
    int         n;
    int         kind;
    act = 2'($urandom_range(0, 3));
    m = (act == ACT_SPARE) ? WM_U64 : width_t'(act);
    fin = (m == WM_U64) ? 9 : 4;
    lim = (m == WM_U64) ? 1 : (m == WM_U32) ? 15 : 7;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 4))
        push_byte(8'($urandom), $urandom_range(0, 7) == 0, 2'($urandom));
    end else begin
      tail_end = ($urandom_range(0, 3) == 0);
      case (kind)
        6: begin
          n = fin + 1;
          tail = 8'($urandom_range(lim + 1, 255));
        end
        7: begin
          n = $urandom_range(2, fin + 1);
          tail = 8'd0;
        end
        8: begin
          n = $urandom_range(1, fin);
          tail = 8'h80 | 8'($urandom_range(0, 127));
          tail_end = 1'b1;
        end
        default: begin
          n = ($urandom_range(0, 3) == 0) ? fin + 1 : $urandom_range(1, fin + 1);
          if (n == 1) tail = 8'($urandom_range(0, 127));
          else if (n == fin + 1) tail = 8'($urandom_range(1, lim));
          else tail = 8'($urandom_range(1, 127));
        end
      endcase
      for (int i = 0; i < n - 1; i++)
        push_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b0, (i == 0) ? act : 2'($urandom));
      push_byte(tail, tail_end, (n == 1) ? act : 2'($urandom));
    end
  endtask

  // Sends every queued byte, one transaction each, with random gaps.
  task automatic drive_bytes();
    byte_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid   <= 1'b1;
      data_byte  <= it.data;
      buffer_end <= it.last;
      action     <= it.act;
      row_typed  <= it.typed;
      row_exp    <= it.exp;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Holds the sender off until every expected result has been received.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls on out_ready.
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Predict on each accepted byte, check each accepted result, and watch for a hang.
  always @(posedge clk) begin
    varint_result_t predicted;
    varint_result_t e;
    bit             fires;
    if (!rst) begin
      if (in_valid && in_ready) begin
        fires = decode_byte(data_byte, buffer_end, action, predicted);
        if (row_typed) pending_results.push_back(row_exp);
        else if (fires) pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: value %h length %0d status %0d",
                     value, length, status);
        end else begin
          e = pending_results.pop_front();
          if (value !== e.value || length !== e.length || status !== e.status) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: value %h/%h length %0d/%0d status %0d/%0d (exp/got)",
                       e.value, value, e.length, length, e.status, status);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every width, every failure kind.
    push_byte(8'h00, 1'b0, ACT_U64, 1'b1, '{64'd0, 4'd1, ST_OK});
    push_byte(8'h7F, 1'b0, ACT_SPARE, 1'b1, '{64'd127, 4'd1, ST_OK});
    push_byte(8'h80, 1'b1, ACT_U64, 1'b1, '{64'd0, 4'd1, ST_TRUNC});
    // A zero continuation byte wins over the buffer end mark.
    push_byte(8'hFF, 1'b0, ACT_U32);
    push_byte(8'h00, 1'b1, ACT_U32, 1'b1, '{64'd0, 4'd2, ST_ZERO});
    // Largest 64-bit value.
    repeat (9) push_byte(8'hFF, 1'b0, ACT_U64);
    push_byte(8'h01, 1'b1, ACT_U64, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 4'd10, ST_OK});
    // Largest 32-bit unsigned value.
    repeat (4) push_byte(8'hFF, 1'b0, ACT_U32);
    push_byte(8'h0F, 1'b0, ACT_U32, 1'b1, '{64'hFFFF_FFFF, 4'd5, ST_OK});
    // Non-negative 31-bit overflow; the action on later bytes is ignored.
    push_byte(8'hFF, 1'b0, ACT_I32);
    repeat (3) push_byte(8'hFF, 1'b0, ACT_U64);
    push_byte(8'h08, 1'b0, ACT_U64, 1'b1, '{64'd0, 4'd5, ST_BIG});
    drive_bytes();

    // Random phases with different idle patterns on each side.
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        plan_value();
        sent += stim_q.size();
        drive_bytes();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
